// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Every check is clocked on clk and is
// switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mep_pkg.sv =====
`default_nettype none

package mep_pkg;

  localparam int FRAC_BITS  = 26;
  localparam int COORD_BITS = 16;
  localparam int COUNT_BITS = 24;
  localparam int VAL_W      = 32;
  localparam int PROD_W     = 2 * VAL_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int PT_W       = COORD_BITS + VAL_W + 1;
  // |z|^2 >= 4.0 in Q(2*FRAC_BITS) means some bit at or above this one is set.
  localparam int ESC_BIT    = 2 * FRAC_BITS + 2;

  localparam int ADDR_W = 5;
  localparam int IDX_W  = 3;
  localparam int DATA_W = 32;

  localparam logic [IDX_W-1:0] REG_MAX_ITER    = 3'd0;
  localparam logic [IDX_W-1:0] REG_ORIGIN_REAL = 3'd1;
  localparam logic [IDX_W-1:0] REG_ORIGIN_IMAG = 3'd2;
  localparam logic [IDX_W-1:0] REG_STEP_REAL   = 3'd3;
  localparam logic [IDX_W-1:0] REG_STEP_IMAG   = 3'd4;

  localparam logic [COUNT_BITS-1:0] MAX_ITER_RST = 24'd1000;
  localparam logic [VAL_W-1:0] ORIGIN_RST = 32'hF800_0000;
  localparam logic [VAL_W-1:0] STEP_RST   = 32'h0004_0000;

  localparam logic [7:0] RED_HIGH = 8'd240;

  typedef struct packed {
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
  } pixel_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] iteration_count;
    logic [7:0]            red;
    logic [7:0]            green_blue;
  } result_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0]   max_iterations;
    logic signed [VAL_W-1:0] origin_real;
    logic signed [VAL_W-1:0] origin_imag;
    logic signed [VAL_W-1:0] step_real;
    logic signed [VAL_W-1:0] step_imag;
  } cfg_t;

  typedef struct packed {
    logic load;     // capture index * step products
    logic form_c;   // form c, clear z and the count
    logic square;   // capture x*x, y*y, x*y
    logic advance;  // write back the new z and bump the count
    logic finish;   // register the result and strobe it
  } cmd_t;

  typedef struct packed {
    logic at_limit;
    logic escaped;
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POINT,
    ST_SQUARE,
    ST_TEST
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/mep_regs.sv =====
`default_nettype none

module mep_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mep_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [mep_pkg::DATA_W-1:0]  pwdata,
  output logic      [mep_pkg::DATA_W-1:0]  prdata,
  output mep_pkg::cfg_t                    cfg
);

  mep_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [mep_pkg::IDX_W-1:0] idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = paddr[mep_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_iterations <= mep_pkg::MAX_ITER_RST;
      cfg_r.origin_real    <= mep_pkg::ORIGIN_RST;
      cfg_r.origin_imag    <= mep_pkg::ORIGIN_RST;
      cfg_r.step_real      <= mep_pkg::STEP_RST;
      cfg_r.step_imag      <= mep_pkg::STEP_RST;
    end else if (wr_en) begin
      unique case (idx)
        mep_pkg::REG_MAX_ITER:    cfg_r.max_iterations <= pwdata[mep_pkg::COUNT_BITS-1:0];
        mep_pkg::REG_ORIGIN_REAL: cfg_r.origin_real    <= pwdata;
        mep_pkg::REG_ORIGIN_IMAG: cfg_r.origin_imag    <= pwdata;
        mep_pkg::REG_STEP_REAL:   cfg_r.step_real      <= pwdata;
        mep_pkg::REG_STEP_IMAG:   cfg_r.step_imag      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      mep_pkg::REG_MAX_ITER:
        prdata = {{(mep_pkg::DATA_W-mep_pkg::COUNT_BITS){1'b0}}, cfg_r.max_iterations};
      mep_pkg::REG_ORIGIN_REAL: prdata = cfg_r.origin_real;
      mep_pkg::REG_ORIGIN_IMAG: prdata = cfg_r.origin_imag;
      mep_pkg::REG_STEP_REAL:   prdata = cfg_r.step_real;
      mep_pkg::REG_STEP_IMAG:   prdata = cfg_r.step_imag;
      default:                  prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/mep_ctrl.sv =====
`default_nettype none

module mep_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire mep_pkg::status_t status,
  output logic                  busy,
  output mep_pkg::cmd_t         cmd
);

  mep_pkg::state_t state_r;
  mep_pkg::state_t state_nxt;
  logic            stop;

  assign stop = status.at_limit | status.escaped;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mep_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mep_pkg::ST_IDLE:   if (start) state_nxt = mep_pkg::ST_POINT;
      mep_pkg::ST_POINT:  state_nxt = mep_pkg::ST_SQUARE;
      mep_pkg::ST_SQUARE: state_nxt = mep_pkg::ST_TEST;
      mep_pkg::ST_TEST:   state_nxt = stop ? mep_pkg::ST_IDLE : mep_pkg::ST_SQUARE;
      default:            state_nxt = mep_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      mep_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      mep_pkg::ST_POINT:  cmd.form_c = 1'b1;
      mep_pkg::ST_SQUARE: cmd.square = 1'b1;
      mep_pkg::ST_TEST: begin
        cmd.finish  = stop;
        cmd.advance = ~stop;
      end
      default: busy = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/mep_dp.sv =====
`default_nettype none

module mep_dp (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire mep_pkg::cmd_t   cmd,
  input  wire mep_pkg::cfg_t   cfg,
  input  wire mep_pkg::pixel_t pixel,
  output mep_pkg::status_t     status,
  output logic                 out_valid,
  output mep_pkg::result_t     out_result
);

  localparam int VW = mep_pkg::VAL_W;
  localparam int SW = mep_pkg::SUM_W;
  localparam int PW = mep_pkg::PT_W;
  localparam int MW = mep_pkg::PROD_W;

  // Clamp a wide signed sum into the 32-bit signed range.
  function automatic logic [VW-1:0] sat_val(input logic [SW-1:0] v);
    logic same;
    same = (&v[SW-1:VW-1]) | ~(|v[SW-1:VW-1]);
    if (same) begin
      return v[VW-1:0];
    end else if (v[SW-1]) begin
      return {1'b1, {(VW-1){1'b0}}};
    end else begin
      return {1'b0, {(VW-1){1'b1}}};
    end
  endfunction

  logic signed [PW-1:0] pt_re_r, pt_im_r, pt_re_nxt, pt_im_nxt;
  logic signed [VW-1:0] c_re_r, c_im_r, c_re_nxt, c_im_nxt;
  logic signed [VW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [MW-1:0] xx_r, yy_r, xy_r, xx_nxt, yy_nxt, xy_nxt;
  logic [mep_pkg::COUNT_BITS-1:0] count_r;
  logic                 out_valid_r;
  mep_pkg::result_t     result_r, result_nxt;

  logic signed [SW-1:0] diff, re_shift, im_shift;
  logic [MW-1:0]        mag;

  // Point formation: index * step, then origin + product with clamping.
  assign pt_re_nxt = PW'($signed({1'b0, pixel.column})) * PW'($signed(cfg.step_real));
  assign pt_im_nxt = PW'($signed({1'b0, pixel.row})) * PW'($signed(cfg.step_imag));

  assign c_re_nxt = sat_val({{(SW-VW){cfg.origin_real[VW-1]}}, cfg.origin_real}
                          + {{(SW-PW){pt_re_r[PW-1]}}, pt_re_r});
  assign c_im_nxt = sat_val({{(SW-VW){cfg.origin_imag[VW-1]}}, cfg.origin_imag}
                          + {{(SW-PW){pt_im_r[PW-1]}}, pt_im_r});

  // Full-width squares and cross product of the current z.
  assign xx_nxt = MW'(x_r) * MW'(x_r);
  assign yy_nxt = MW'(y_r) * MW'(y_r);
  assign xy_nxt = MW'(x_r) * MW'(y_r);

  // Arithmetic shifts round toward minus infinity.
  assign diff     = $signed({xx_r[MW-1], xx_r}) - $signed({yy_r[MW-1], yy_r});
  assign re_shift = diff >>> mep_pkg::FRAC_BITS;
  assign im_shift = $signed({xy_r[MW-1], xy_r}) >>> (mep_pkg::FRAC_BITS - 1);

  assign x_nxt = sat_val(re_shift + {{(SW-VW){c_re_r[VW-1]}}, c_re_r});
  assign y_nxt = sat_val(im_shift + {{(SW-VW){c_im_r[VW-1]}}, c_im_r});

  // Both squares are non-negative and at most 2^62, so the sum cannot wrap.
  assign mag = xx_r + yy_r;

  assign status.escaped  = |mag[MW-1:mep_pkg::ESC_BIT];
  assign status.at_limit = ~(count_r < cfg.max_iterations);

  always_comb begin
    result_nxt.iteration_count = count_r;
    result_nxt.red             = '0;
    result_nxt.green_blue      = '0;
    if (count_r != cfg.max_iterations) begin
      if (count_r[4]) begin
        result_nxt.red        = mep_pkg::RED_HIGH;
        result_nxt.green_blue = {count_r[3:0], 4'b0000};
      end else begin
        result_nxt.red = {count_r[3:0], 4'b0000};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pt_re_r <= pt_re_nxt;
      pt_im_r <= pt_im_nxt;
    end
    if (cmd.form_c) begin
      c_re_r  <= c_re_nxt;
      c_im_r  <= c_im_nxt;
      x_r     <= '0;
      y_r     <= '0;
      count_r <= '0;
    end else if (cmd.advance) begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      count_r <= count_r + {{(mep_pkg::COUNT_BITS-1){1'b0}}, 1'b1};
    end
    if (cmd.square) begin
      xx_r <= xx_nxt;
      yy_r <= yy_nxt;
      xy_r <= xy_nxt;
    end
    if (cmd.finish) begin
      result_r <= result_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = result_r;

endmodule

`default_nettype wire

// ===== rtl/mandelbrot_escape_pixel.sv =====
// Mandelbrot escape-time evaluator for one pixel per request.
// A request is taken at a rising clock edge where start is high and busy is
// low; in_pixel carries the column and row. The block maps them to the point
// c = (origin_real + column*step_real) + i*(origin_imag + row*step_imag) in
// signed Q6.26, iterates z = z^2 + c from zero, and stops at the iteration
// limit or once |z|^2 reaches 4.0.
// The result (count plus palette color) is held on out_result and flagged by
// out_valid for exactly one cycle. The receiver cannot stall it, so it must
// take the result in that cycle.
// For a pixel that runs n iterations, the point state forms c, then each of
// the n iterations and the final test take a square state on the three
// 32x32 multipliers and a test/update state. busy drops as the result is
// shown, so the next request can be taken at the edge that ends the result
// cycle; the block does not take a new pixel before the last one is done.
// The APB-style port holds the limit, origin and step registers; write them
// only while busy is low. Reset (rst_n low at a clock edge) returns the
// registers to their defaults, the controller to idle and clears out_valid.
`default_nettype none

module mandelbrot_escape_pixel (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire mep_pkg::pixel_t             in_pixel,
  output logic                             out_valid,
  output mep_pkg::result_t                 out_result,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mep_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [mep_pkg::DATA_W-1:0]  pwdata,
  output logic      [mep_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);

  `include "assert_macros.svh"

  mep_pkg::cfg_t    cfg;
  mep_pkg::cmd_t    cmd;
  mep_pkg::status_t status;

  // The register file never inserts wait states.
  assign pready = 1'b1;

  mep_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // The controller sequences point formation and the iteration loop.
  mep_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // The datapath holds c, z, the products, the count and the result register.
  mep_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg        (cfg),
    .pixel      (in_pixel),
    .status     (status),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  // A result is only ever shown once the controller is back in idle.
  `CHK_ALWAYS(a_result_when_idle, !out_valid || !busy, "result shown while busy")

  // An accepted request always makes the block busy on the next cycle.
  `CHK_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")

  // The count never runs past the limit.
  `CHK_ALWAYS(a_count_bound, !out_valid || (out_result.iteration_count <= cfg.max_iterations),
              "iteration count exceeds limit")

  // A pixel that hit the limit is black.
  `CHK_ALWAYS(a_limit_black,
              !(out_valid && (out_result.iteration_count == cfg.max_iterations))
              || (out_result.red == 8'd0 && out_result.green_blue == 8'd0),
              "pixel at limit is not black")

endmodule

`default_nettype wire
